/* rtl/lgh_pkg.sv */
// Package for the level gate with hold: sizes, reset values, register
// indexes and event codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lgh_pkg;

  localparam int MAX_CHUNK_SAMPLES = 65536;
  localparam int SAMPLE_W = 16;
  localparam int TIME_W = 32;
  localparam int MEAN_W = 16;
  localparam int EVT_W = 2;
  localparam int CNT_W = $clog2(MAX_CHUNK_SAMPLES + 1);
  localparam int SUM_W = $clog2(longint'(MAX_CHUNK_SAMPLES) * 32768 + 1);
  localparam int DIV_STEPS = MEAN_W;
  localparam int STEP_W = $clog2(DIV_STEPS);

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_HOLD = 2'd1;
  localparam logic [1:0] REG_ENABLE = 2'd2;

  localparam logic [15:0] THRESHOLD_RESET = 16'd1024;
  localparam logic [15:0] HOLD_RESET = 16'd500;
  localparam logic [TIME_W-1:0] SILENT_RESET = 32'd2000;

  localparam logic [EVT_W-1:0] EVT_NONE = 2'd0;
  localparam logic [EVT_W-1:0] EVT_MUTE = 2'd1;
  localparam logic [EVT_W-1:0] EVT_UNMUTE = 2'd2;

endpackage

`default_nettype wire

/* rtl/level_gate_with_hold.sv */
// Level gate with hold: top level, accumulator, bit-serial divider, gate logic
// and APB register file. Depends on lgh_pkg.
//
// Usage: samples arrive on the s_axis channel, one transfer per sample;
// s_axis_tlast marks the last sample of a chunk and now_ms is read only then.
// Each non-final sample is added to the sum and produces nothing. The final
// sample starts a restoring divider that yields one quotient bit per cycle;
// the final state then updates the gate state and loads the result register,
// which drives m_axis, once that register is free. Throughput: one sample per
// cycle inside a chunk; s_axis is held off while the serial divider and final
// state finish a chunk. Input is accepted while a finished result waits; a
// stalled receiver holds the next chunk only at its divider output.
// Reset (synchronous, rst high) clears sum and count, turns attenuation off,
// sets silence time to 2000 ms and loads register defaults.
// Registers (APB, byte address 4*i): 0 level_threshold, 1 hold_ms,
// 2 target_enabled. pready is always high.
`timescale 1ns / 1ps
`default_nettype none

module level_gate_with_hold (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  // [15:0] sample, [47:16] now_ms
  input  wire logic [47:0]               s_axis_tdata,
  // chunk_end
  input  wire logic                      s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  // [15:0] mean_level, [16] attenuating, [18:17] mute_event, [23:19] zero
  output logic [23:0]                    m_axis_tdata,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [lgh_pkg::APB_AW-1:0] paddr,
  input  wire logic [lgh_pkg::APB_DW-1:0] pwdata,
  output logic [lgh_pkg::APB_DW-1:0]     prdata,
  output logic                           pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV = 2'd1;
  localparam logic [1:0] ST_FIN = 2'd2;

  localparam int CW = lgh_pkg::CNT_W;
  localparam int QW = lgh_pkg::MEAN_W;
  localparam int TW = lgh_pkg::TIME_W;

  logic [1:0] state;
  logic [15:0] level_threshold;
  logic [15:0] hold_ms;
  logic target_enabled;

  logic [lgh_pkg::SUM_W-1:0] abs_sum;
  logic [CW-1:0] sample_count;
  logic attenuate_flag;
  logic [TW-1:0] silent_ms;
  logic [TW-1:0] last_time_ms;
  logic [TW-1:0] elapsed;

  logic [CW-1:0] rem;
  logic [CW-1:0] divisor;
  logic [QW-1:0] dq;
  logic [lgh_pkg::STEP_W-1:0] step;

  logic [QW-1:0] out_mean;
  logic out_att;
  logic [lgh_pkg::EVT_W-1:0] out_evt;
  logic out_valid;

  logic in_xfer;
  logic wr_xfer;
  logic [15:0] sample;
  logic [TW-1:0] now_ms;
  logic [15:0] mag;
  logic room;
  logic [lgh_pkg::SUM_W-1:0] sum_next;
  logic [CW-1:0] count_next;
  logic [CW:0] shifted;
  logic [CW+1:0] diff;
  logic [TW:0] silent_sum;
  logic out_free;
  logic above;
  logic att_next;
  logic [lgh_pkg::EVT_W-1:0] evt_next;
  logic [TW-1:0] silent_next;

  assign pready = 1'b1;
  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign wr_xfer = psel && penable && pwrite && pready;
  assign s_axis_tready = (state == ST_IDLE);
  assign sample = s_axis_tdata[15:0];
  assign now_ms = s_axis_tdata[47:16];

  // |-32768| wraps to 0x8000, read as 32768 unsigned
  assign mag = sample[15] ? (~sample + 16'd1) : sample;
  assign room = (sample_count < CW'(lgh_pkg::MAX_CHUNK_SAMPLES));
  assign sum_next = room ? (abs_sum + lgh_pkg::SUM_W'(mag)) : abs_sum;
  assign count_next = room ? (sample_count + CW'(1)) : sample_count;

  assign shifted = {rem, dq[QW-1]};
  assign diff = {1'b0, shifted} - {2'b00, divisor};

  assign silent_sum = {1'b0, silent_ms} + {1'b0, elapsed};
  assign out_free = !out_valid || m_axis_tready;
  assign above = (dq > level_threshold);

  always_comb begin
    att_next = attenuate_flag;
    evt_next = lgh_pkg::EVT_NONE;
    silent_next = silent_ms;
    if (above) begin
      if (!attenuate_flag) begin
        att_next = 1'b1;
        if (target_enabled) begin
          evt_next = lgh_pkg::EVT_MUTE;
        end
      end
      silent_next = '0;
    end else begin
      if ((silent_ms >= TW'(hold_ms)) && attenuate_flag) begin
        att_next = 1'b0;
        if (target_enabled) begin
          evt_next = lgh_pkg::EVT_UNMUTE;
        end
      end
      silent_next = silent_sum[TW] ? '1 : silent_sum[TW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      abs_sum <= '0;
      sample_count <= '0;
      attenuate_flag <= 1'b0;
      silent_ms <= lgh_pkg::SILENT_RESET;
      last_time_ms <= '0;
      out_valid <= 1'b0;
      step <= '0;
    end else begin
      if (out_valid && m_axis_tready && (state != ST_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            if (s_axis_tlast) begin
              abs_sum <= '0;
              sample_count <= '0;
              rem <= CW'(sum_next >> QW);
              dq <= sum_next[QW-1:0];
              divisor <= count_next;
              elapsed <= now_ms - last_time_ms;
              last_time_ms <= now_ms;
              step <= '0;
              state <= ST_DIV;
            end else begin
              abs_sum <= sum_next;
              sample_count <= count_next;
            end
          end
        end
        ST_DIV: begin
          if (diff[CW+1]) begin
            rem <= shifted[CW-1:0];
            dq <= {dq[QW-2:0], 1'b0};
          end else begin
            rem <= diff[CW-1:0];
            dq <= {dq[QW-2:0], 1'b1};
          end
          step <= step + lgh_pkg::STEP_W'(1);
          if (step == lgh_pkg::STEP_W'(lgh_pkg::DIV_STEPS - 1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            attenuate_flag <= att_next;
            silent_ms <= silent_next;
            out_mean <= dq;
            out_att <= att_next;
            out_evt <= evt_next;
            out_valid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      level_threshold <= lgh_pkg::THRESHOLD_RESET;
      hold_ms <= lgh_pkg::HOLD_RESET;
      target_enabled <= 1'b1;
    end else if (wr_xfer) begin
      case (paddr[3:2])
        lgh_pkg::REG_THRESHOLD: level_threshold <= pwdata[15:0];
        lgh_pkg::REG_HOLD: hold_ms <= pwdata[15:0];
        lgh_pkg::REG_ENABLE: target_enabled <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      lgh_pkg::REG_THRESHOLD: prdata = {16'd0, level_threshold};
      lgh_pkg::REG_HOLD: prdata = {16'd0, hold_ms};
      lgh_pkg::REG_ENABLE: prdata = {31'd0, target_enabled};
      default: prdata = '0;
    endcase
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {5'd0, out_evt, out_att, out_mean};

  a_chunk_starts_div: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && s_axis_tlast) |=> (state == ST_DIV))
    else $error("chunk end did not start the divider");

  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && step == lgh_pkg::STEP_W'(lgh_pkg::DIV_STEPS - 1)) |=> (state == ST_FIN))
    else $error("divider did not finish after its last step");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < divisor))
    else $error("divider remainder not below divisor");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    sample_count <= CW'(lgh_pkg::MAX_CHUNK_SAMPLES))
    else $error("sample count beyond chunk limit");

  a_event_matches_state: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_evt == lgh_pkg::EVT_MUTE)) |-> out_att)
    else $error("mute event without attenuation");

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// Testbench for level_gate_with_hold: directed and random sample streams with
// per-chunk level gate predictions checked against m_axis transfers.
// Depends on lgh_pkg and the level_gate_with_hold RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 24;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [31:0] now;
    logic        last;
    logic [15:0] smp;
  } audio_xfer_t;

  typedef struct {
    logic [15:0]               mean;
    logic                      att;
    logic [lgh_pkg::EVT_W-1:0] evt;
  } gate_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [lgh_pkg::APB_AW-1:0] paddr = '0;
  logic [lgh_pkg::APB_DW-1:0] pwdata = '0;
  logic [lgh_pkg::APB_DW-1:0] prdata;
  logic pready;

  level_gate_with_hold uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // stimulus and expectations
  audio_xfer_t  pending_xfers[$];
  gate_report_t chunk_reports_due[$];

  // gate model state and register copy
  longint unsigned acc_sum;
  int unsigned     acc_count;
  logic            gate_on;
  logic [31:0]     quiet_ms;
  logic [31:0]     prev_end_ms;
  logic [15:0]     gate_thr;
  logic [15:0]     gate_hold;
  logic            gate_notify;

  logic in_taken = 1'b0;
  logic out_taken = 1'b0;
  audio_xfer_t next_xfer;
  int  send_gap = 0;
  bit  send_burst = 1'b0;
  int  take_wait = 0;
  bit  take_burst = 1'b0;

  int cycle_count = 0;
  int errors = 0;
  int n_samples = 0;
  int n_reports = 0;
  int n_mutes = 0;
  int n_unmutes = 0;
  int cfg_thr = 1024;
  int cfg_hold = 500;
  logic [31:0] now_base = '0;
  int phase_thr[6] = '{0, 32768, 300, 4000, 0, 1024};
  int phase_hold[6] = '{0, 65535, 0, 1500, 0, 500};
  int phase_en[6] = '{1, 1, 0, 1, 0, 1};

  task automatic gate_predict(input logic [15:0] smp, input logic last,
                              input logic [31:0] now);
    logic [31:0] mag;
    logic [31:0] mean;
    logic [31:0] elapsed;
    gate_report_t rep;
    if (acc_count < lgh_pkg::MAX_CHUNK_SAMPLES) begin
      mag = smp[15] ? 32'h10000 - {16'd0, smp} : {16'd0, smp};
      acc_sum += mag;
      acc_count++;
    end
    if (last) begin
      mean = (acc_count != 0) ? 32'(acc_sum / acc_count) : '0;
      rep.evt = lgh_pkg::EVT_NONE;
      if (mean > {16'd0, gate_thr}) begin
        if (!gate_on) begin
          gate_on = 1'b1;
          if (gate_notify) rep.evt = lgh_pkg::EVT_MUTE;
        end
        quiet_ms = '0;
      end else begin
        if (quiet_ms >= {16'd0, gate_hold} && gate_on) begin
          gate_on = 1'b0;
          if (gate_notify) rep.evt = lgh_pkg::EVT_UNMUTE;
        end
        elapsed = now - prev_end_ms;
        quiet_ms = (quiet_ms > 32'hFFFF_FFFF - elapsed) ? 32'hFFFF_FFFF : quiet_ms + elapsed;
      end
      prev_end_ms = now;
      acc_sum = 0;
      acc_count = 0;
      rep.mean = mean[15:0];
      rep.att = gate_on;
      if (rep.evt == lgh_pkg::EVT_MUTE) n_mutes++;
      if (rep.evt == lgh_pkg::EVT_UNMUTE) n_unmutes++;
      chunk_reports_due.push_back(rep);
    end
  endtask

  // sample side
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (in_taken) begin
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 11);
      end
      if (send_gap != 0 || pending_xfers.size() == 0) begin
        s_axis_tvalid <= 1'b0;
        if (send_gap != 0) send_gap--;
      end else begin
        next_xfer = pending_xfers.pop_front();
        s_axis_tdata <= {next_xfer.now, next_xfer.smp};
        s_axis_tlast <= next_xfer.last;
        s_axis_tvalid <= 1'b1;
      end
    end
  end

  // report side
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      take_wait = $urandom_range(0, 11);
    end else begin
      if (out_taken) begin
        if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
        take_wait = take_burst ? 0 : $urandom_range(0, 11);
      end else if (take_wait != 0) begin
        take_wait--;
      end
      m_axis_tready <= (take_wait == 0);
    end
  end

  // prediction on input transfers, checking on output transfers
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("level_gate_with_hold regression: fail");
      $finish;
    end else if (rst) begin
      in_taken <= 1'b0;
      out_taken <= 1'b0;
      acc_sum = 0;
      acc_count = 0;
      gate_on = 1'b0;
      quiet_ms = lgh_pkg::SILENT_RESET;
      prev_end_ms = '0;
      gate_thr = lgh_pkg::THRESHOLD_RESET;
      gate_hold = lgh_pkg::HOLD_RESET;
      gate_notify = 1'b1;
    end else begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      out_taken <= m_axis_tvalid && m_axis_tready;
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          lgh_pkg::REG_THRESHOLD: gate_thr = pwdata[15:0];
          lgh_pkg::REG_HOLD:      gate_hold = pwdata[15:0];
          lgh_pkg::REG_ENABLE:    gate_notify = pwdata[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        n_samples++;
        gate_predict(s_axis_tdata[15:0], s_axis_tlast, s_axis_tdata[47:16]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        n_reports++;
        if (chunk_reports_due.size() == 0) begin
          errors++;
          $display("%0t: report with none expected: expected nothing, got %h",
                   $time, m_axis_tdata);
        end else begin
          automatic gate_report_t want = chunk_reports_due.pop_front();
          if (m_axis_tdata[15:0] !== want.mean) begin
            errors++;
            $display("%0t: mean_level expected %0d, got %0d", $time, want.mean,
                     m_axis_tdata[15:0]);
          end
          if (m_axis_tdata[16] !== want.att) begin
            errors++;
            $display("%0t: attenuating expected %0d, got %0d", $time, want.att,
                     m_axis_tdata[16]);
          end
          if (m_axis_tdata[18:17] !== want.evt) begin
            errors++;
            $display("%0t: mute_event expected %0d, got %0d", $time, want.evt,
                     m_axis_tdata[18:17]);
          end
        end
      end
    end
  end

  function automatic audio_xfer_t xfer(input logic [15:0] smp, input logic last,
                                       input logic [31:0] now);
    audio_xfer_t x;
    x.smp = smp;
    x.last = last;
    x.now = now;
    return x;
  endfunction

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (pending_xfers.size() != 0 || s_axis_tvalid || chunk_reports_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // chunks shaped around the current threshold and hold time
  task automatic queue_random_chunks(input int n_items);
    int left, len, kind, amp, mag;
    logic [15:0] smp;
    logic [31:0] step;
    left = n_items;
    while (left > 0) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
      kind = $urandom_range(0, 9);
      if (kind < 4) amp = $urandom_range(0, (cfg_thr > 8190) ? 32768 : 4 * cfg_thr + 8);
      else if (kind == 6) amp = 32768;
      else amp = 64;
      for (int i = 0; i < len; i++) begin
        if (kind == 4 || kind == 5)
          mag = (cfg_thr + kind - 4 > 32768) ? 32768 : cfg_thr + kind - 4;
        else
          mag = $urandom_range(0, amp);
        if (kind == 6) smp = 16'($urandom);
        else if (mag == 32768) smp = 16'h8000;
        else if ($urandom_range(0, 1) == 1) smp = 16'(-mag);
        else smp = 16'(mag);
        if (i == len - 1) begin
          case ($urandom_range(0, 15))
            0: step = $urandom;
            1: step = '0;
            default: step = $urandom_range(0, cfg_hold / 2 + 64);
          endcase
          now_base += step;
          pending_xfers.push_back(xfer(smp, 1'b1, now_base));
        end else begin
          pending_xfers.push_back(xfer(smp, 1'b0, $urandom));
        end
      end
      left -= len;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: first chunk, mute, hold, unmute, time wrap, saturation
    pending_xfers.push_back(xfer(16'h0000, 1'b1, 32'd1234));
    pending_xfers.push_back(xfer(16'h8000, 1'b0, 32'hFFFF_FFFF));
    pending_xfers.push_back(xfer(16'h7FFF, 1'b1, 32'd1300));
    pending_xfers.push_back(xfer(16'hFFFF, 1'b0, 32'd0));
    pending_xfers.push_back(xfer(16'h0001, 1'b0, 32'hAAAA_5555));
    pending_xfers.push_back(xfer(16'h0000, 1'b0, 32'h5555_AAAA));
    pending_xfers.push_back(xfer(16'h0400, 1'b1, 32'd1500));
    pending_xfers.push_back(xfer(16'hFC00, 1'b1, 32'd1800));
    pending_xfers.push_back(xfer(16'h0000, 1'b1, 32'd1800));
    pending_xfers.push_back(xfer(16'h0001, 1'b1, 32'hFFFF_FF00));
    pending_xfers.push_back(xfer(16'hFBFF, 1'b1, 32'h0000_0040));
    pending_xfers.push_back(xfer(16'h0000, 1'b1, 32'hFFFF_FFF0));
    pending_xfers.push_back(xfer(16'h0000, 1'b1, 32'hFFFF_FFE0));
    pending_xfers.push_back(xfer(16'h0003, 1'b0, 32'h0000_0000));
    pending_xfers.push_back(xfer(16'hFFFE, 1'b1, 32'hFFFF_FFE1));
    pending_xfers.push_back(xfer(16'h5555, 1'b0, 32'h0F0F_F0F0));
    pending_xfers.push_back(xfer(16'hAAAA, 1'b1, 32'hFFFF_FFE2));
    now_base = 32'hFFFF_FFE2;
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      cfg_thr = (p == 4) ? $urandom_range(0, 32768) : phase_thr[p];
      cfg_hold = (p == 4) ? $urandom_range(0, 65535) : phase_hold[p];
      apb_write(lgh_pkg::REG_THRESHOLD, 32'(cfg_thr));
      apb_write(lgh_pkg::REG_HOLD, 32'(cfg_hold));
      apb_write(lgh_pkg::REG_ENABLE,
                (p == 4) ? 32'($urandom_range(0, 1)) : 32'(phase_en[p]));
      if (p == 0) apb_write(REG_UNUSED, 32'h0000_FFFF);
      queue_random_chunks(100);
      wait_idle();
    end

    $display("run covered %0d samples in %0d chunk reports over 6 register settings",
             n_samples, n_reports);
    $display("attenuation on events: %0d, off events: %0d, errors: %0d",
             n_mutes, n_unmutes, errors);
    if (errors == 0) begin
      $display("level_gate_with_hold regression: pass");
    end else begin
      $display("level_gate_with_hold regression: fail");
    end
    $finish;
  end

endmodule
